/* src/linear_blend_vertex_skinning_top_defines.svh */
// Assertion macros shared by the skinning block
`ifndef LINEAR_BLEND_VERTEX_SKINNING_TOP_DEFINES_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_TOP_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define LBS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle
`define LBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/lbs_pkg.sv */
// Shared types, constants and helpers for the skinning block
`default_nettype none
package lbs_pkg;

	localparam int BONE_SLOTS     = 64;
	localparam int MAX_INFLUENCES = 4;
	localparam int WORDS_PER_BONE = 12;
	localparam int PALETTE_WORDS  = BONE_SLOTS * WORDS_PER_BONE;
	localparam int ROW_W          = 6;
	localparam int ELEM_W         = 4;
	// addr * 683 >> 13 equals addr / 12 for every address below 768
	localparam int RECIP          = 683;
	localparam int RECIP_SH       = 13;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SKIN  = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [9:0]         palette_address;
		logic signed [31:0] palette_value;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] norm_x;
		logic signed [31:0] norm_y;
		logic signed [31:0] norm_z;
		logic [23:0]        bone_indices;
		logic [63:0]        bone_weights;
		logic               last_vertex;
	} req_t;

	typedef struct packed {
		logic signed [31:0] out_pos_x;
		logic signed [31:0] out_pos_y;
		logic signed [31:0] out_pos_z;
		logic signed [31:0] out_norm_x;
		logic signed [31:0] out_norm_y;
		logic signed [31:0] out_norm_z;
		logic               out_last;
	} res_t;

	typedef logic [WORDS_PER_BONE-1:0][31:0] bone_row_t;

	typedef struct packed {
		logic        en;
		logic [9:0]  addr;
		logic [31:0] data;
	} pal_wr_t;

	// Clamp a wide sum to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
		logic signed [31:0] r;
		if (x > 50'sh0_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < -50'sh0_0000_8000_0000) begin
			r = -32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* src/linear_blend_vertex_skinning_top.sv */
// Linear blend skinning top level: palette, blend and transform sequencer
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | req_data (lbs_pkg::req_t)
//   res     | out       | res_valid / res_stall  | res_data (lbs_pkg::res_t)
//
// A vertex makes one palette row read per counted influence (one to four), then three
// row steps of the transform through six shared multipliers.
// Reset clears the sequencer and the result valid flag; palette contents stay
// undefined until written. A stalled result holds; the next request is taken
// while it waits, and a vertex waits in its final step until the register frees.
`default_nettype none
module linear_blend_vertex_skinning_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  lbs_pkg::req_t req_data,
	output logic          res_valid,
	input  logic          res_stall,
	output lbs_pkg::res_t res_data
);
	import lbs_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_BLEND, ST_XFORM, ST_FIN} state_t;

	state_t             state_q;
	req_t               vtx_q;
	logic [2:0]         cnt_q;
	logic [2:0]         k_q;
	logic [1:0]         x_q;
	logic               res_valid_q;
	res_t               res_q;

	logic               rd_v_s1;
	logic [15:0]        w_s1;
	logic               ok_s1;
	logic               v_s2;
	logic signed [32:0] prod_s2 [WORDS_PER_BONE];
	logic signed [34:0] acc_q [WORDS_PER_BONE];
	logic signed [31:0] t_q [WORDS_PER_BONE];
	logic               xv_s1;
	logic signed [47:0] xprod_s1 [6];
	logic signed [49:0] sum_q [6];

	logic               accept;
	logic [2:0]         n_infl;
	logic               run;
	logic               issue;
	logic [ROW_W-1:0]   rd_slot;
	logic               slot_ok;
	bone_row_t          rd_row;
	pal_wr_t            wr;
	logic signed [48:0] bprod [WORDS_PER_BONE];
	logic               blend_done;
	logic               xissue;
	logic signed [31:0] pv;
	logic signed [31:0] nv;
	logic [3:0]         xbase;
	logic signed [63:0] xm [6];
	logic               fin_load;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Route palette writes to the memory
	always_comb begin
		wr.en   = accept && (req_data.operation == OP_WRITE);
		wr.addr = req_data.palette_address;
		wr.data = req_data.palette_value;
	end

	// Count leading influences: first always, later ones while weights stay nonzero
	always_comb begin
		n_infl = 3'd1;
		run    = 1'b1;
		for (int k = 1; k < 4; k++) begin
			if (k < MAX_INFLUENCES && run && req_data.bone_weights[16*k +: 16] != 16'd0) begin
				n_infl = 3'(k + 1);
			end else begin
				run = 1'b0;
			end
		end
	end

	// Issue one palette row read per counted influence
	assign issue   = (state_q == ST_BLEND) && (k_q < cnt_q);
	assign rd_slot = vtx_q.bone_indices[6*k_q[1:0] +: 6];
	assign slot_ok = int'(rd_slot) < BONE_SLOTS;

	lbs_palette u_palette (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (issue),
		.rd_slot (rd_slot),
		.rd_row  (rd_row)
	);

	// Weight each element of the fetched row
	always_comb begin
		for (int e = 0; e < WORDS_PER_BONE; e++) begin
			bprod[e] = $signed(rd_row[e]) * $signed({1'b0, w_s1});
		end
	end

	assign blend_done = (state_q == ST_BLEND) && !issue && !rd_v_s1 && !v_s2;
	assign xissue     = (state_q == ST_XFORM) && (x_q != 2'd3);
	assign fin_load   = (state_q == ST_FIN) && (!res_valid_q || !res_stall);

	// Pick the input row for this transform step
	always_comb begin
		case (x_q)
			2'd0: begin
				pv = vtx_q.pos_x;
				nv = vtx_q.norm_x;
			end
			2'd1: begin
				pv = vtx_q.pos_y;
				nv = vtx_q.norm_y;
			end
			default: begin
				pv = vtx_q.pos_z;
				nv = vtx_q.norm_z;
			end
		endcase
		xbase = 4'(3 * x_q);
		for (int c = 0; c < 3; c++) begin
			xm[c]     = pv * t_q[xbase + 4'(c)];
			xm[3 + c] = nv * t_q[xbase + 4'(c)];
		end
	end

	// Sequencer and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= 3'd0;
			k_q         <= 3'd0;
			x_q         <= 2'd0;
			rd_v_s1     <= 1'b0;
			v_s2        <= 1'b0;
			xv_s1       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			v_s2    <= rd_v_s1;
			xv_s1   <= xissue;
			// Raise valid on a new result, drop it once taken
			if (fin_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && req_data.operation == OP_SKIN) begin
						cnt_q   <= n_infl;
						k_q     <= 3'd0;
						state_q <= ST_BLEND;
					end
				end
				ST_BLEND: begin
					if (issue) begin
						k_q <= k_q + 3'd1;
					end
					if (blend_done) begin
						x_q     <= 2'd0;
						state_q <= ST_XFORM;
					end
				end
				ST_XFORM: begin
					if (xissue) begin
						x_q <= x_q + 2'd1;
					end
					if (!xissue && !xv_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: blend accumulation, transform sums, result register
	always_ff @(posedge clk) begin
		if (accept) begin
			vtx_q <= req_data;
		end
		if (issue) begin
			w_s1  <= vtx_q.bone_weights[16*k_q[1:0] +: 16];
			ok_s1 <= slot_ok;
		end
		// Hold the floored product, zero for a slot outside the palette
		if (rd_v_s1) begin
			for (int e = 0; e < WORDS_PER_BONE; e++) begin
				prod_s2[e] <= ok_s1 ? bprod[e][47:15] : 33'sd0;
			end
		end
		// Clear while idle, add each weighted row
		for (int e = 0; e < WORDS_PER_BONE; e++) begin
			if (state_q == ST_IDLE) begin
				acc_q[e] <= 35'sd0;
			end else if (v_s2) begin
				acc_q[e] <= acc_q[e] + 35'(prod_s2[e]);
			end
		end
		// Saturate the blended matrix, seed the position sums with the translation, clear the normal sums
		if (blend_done) begin
			for (int e = 0; e < WORDS_PER_BONE; e++) begin
				t_q[e] <= sat32(50'(acc_q[e]));
			end
			for (int c = 0; c < 3; c++) begin
				sum_q[c]     <= 50'(sat32(50'(acc_q[9 + c])));
				sum_q[3 + c] <= 50'sd0;
			end
		end
		if (xissue) begin
			for (int i = 0; i < 6; i++) begin
				xprod_s1[i] <= xm[i][63:16];
			end
		end
		if (xv_s1) begin
			for (int i = 0; i < 6; i++) begin
				sum_q[i] <= sum_q[i] + 50'(xprod_s1[i]);
			end
		end
		if (fin_load) begin
			res_q.out_pos_x  <= sat32(sum_q[0]);
			res_q.out_pos_y  <= sat32(sum_q[1]);
			res_q.out_pos_z  <= sat32(sum_q[2]);
			res_q.out_norm_x <= sat32(sum_q[3]);
			res_q.out_norm_y <= sat32(sum_q[4]);
			res_q.out_norm_z <= sat32(sum_q[5]);
			res_q.out_last   <= vtx_q.last_vertex;
		end
	end

`include "linear_blend_vertex_skinning_top_defines.svh"

	`LBS_ASSERT_NEXT(a_skin_starts_blend, accept && req_data.operation == OP_SKIN, state_q == ST_BLEND, "vertex request did not start blending")
	`LBS_ASSERT_NOW(a_reads_bounded, state_q == ST_BLEND, k_q <= cnt_q, "more palette reads than counted influences")
	`LBS_ASSERT_NOW(a_blend_drained, state_q == ST_XFORM, !rd_v_s1 && !v_s2, "blend pipeline busy during transform")

endmodule
`default_nettype wire

/* src/lbs_palette.sv */
// Bone palette memory: one word written, one whole matrix row read per cycle
`default_nettype none
module lbs_palette (
	input  logic                        clk,
	input  lbs_pkg::pal_wr_t            wr,
	input  logic                        rd_en,
	input  logic [lbs_pkg::ROW_W-1:0]   rd_slot,
	output lbs_pkg::bone_row_t          rd_row
);
	import lbs_pkg::*;

	bone_row_t          mem [BONE_SLOTS];
	logic [19:0]        quot_full;
	logic [ROW_W-1:0]   row;
	logic [9:0]         row_base;
	logic [9:0]         diff;
	logic [ELEM_W-1:0]  elem;
	logic               in_range;

	// Split the word address into slot and element
	always_comb begin
		quot_full = {10'd0, wr.addr} * 20'(RECIP);
		row       = quot_full[RECIP_SH +: ROW_W];
		row_base  = {4'd0, row} * 10'(WORDS_PER_BONE);
		diff      = wr.addr - row_base;
		elem      = diff[ELEM_W-1:0];
		in_range  = wr.addr < 10'(PALETTE_WORDS);
	end

	// Write one word, read one row
	always_ff @(posedge clk) begin
		if (wr.en && in_range) begin
			mem[row][elem] <= wr.data;
		end
		if (rd_en) begin
			rd_row <= mem[rd_slot];
		end
	end

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Testbench for the linear blend skinning block: directed table, then random requests
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import lbs_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int RANDOM_ITEMS   = 1500;
	localparam int DIRECTED_ROWS  = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data = '0;
	logic res_valid;
	logic res_stall = 1'b1;
	res_t res_data;

	linear_blend_vertex_skinning_top dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
	);

	always #5 clk = ~clk;

	// Shadow palette and written marks
	logic signed [31:0] palette_shadow [PALETTE_WORDS];
	bit palette_written [PALETTE_WORDS];
	res_t skinned_queue[$];
	int fail_count = 0;
	int idle_cycles = 0;
	bit hold_off = 1'b0;

	function automatic longint floor_sh(longint x, int n);
		return x >>> n;
	endfunction

	function automatic longint clamp32(longint x);
		if (x > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (x < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return x;
	endfunction

	// Predict one vertex result from the shadow palette
	function automatic res_t skin_vertex(req_t rq);
		longint acc [WORDS_PER_BONE];
		longint blended [WORDS_PER_BONE];
		longint pv [3];
		longint nv [3];
		longint sp, sn, w;
		int slot;
		res_t r;
		for (int e = 0; e < WORDS_PER_BONE; e++) acc[e] = 0;
		for (int k = 0; k < MAX_INFLUENCES; k++) begin
			slot = int'(rq.bone_indices[6*k +: 6]);
			w = longint'(rq.bone_weights[16*k +: 16]);
			if (k > 0 && w == 0) break;
			if (slot >= BONE_SLOTS) continue;
			for (int e = 0; e < WORDS_PER_BONE; e++)
				acc[e] += floor_sh(longint'(palette_shadow[slot*WORDS_PER_BONE + e]) * w, 15);
		end
		for (int e = 0; e < WORDS_PER_BONE; e++) blended[e] = clamp32(acc[e]);
		pv[0] = rq.pos_x;  pv[1] = rq.pos_y;  pv[2] = rq.pos_z;
		nv[0] = rq.norm_x; nv[1] = rq.norm_y; nv[2] = rq.norm_z;
		for (int c = 0; c < 3; c++) begin
			sp = blended[9 + c];
			sn = 0;
			for (int row = 0; row < 3; row++) begin
				sp += floor_sh(pv[row] * blended[row*3 + c], 16);
				sn += floor_sh(nv[row] * blended[row*3 + c], 16);
			end
			case (c)
				0: begin r.out_pos_x = 32'(clamp32(sp)); r.out_norm_x = 32'(clamp32(sn)); end
				1: begin r.out_pos_y = 32'(clamp32(sp)); r.out_norm_y = 32'(clamp32(sn)); end
				default: begin
					r.out_pos_z = 32'(clamp32(sp)); r.out_norm_z = 32'(clamp32(sn));
				end
			endcase
		end
		r.out_last = rq.last_vertex;
		return r;
	endfunction

	// Apply one accepted request to the shadow state
	function automatic void absorb_request(req_t rq);
		if (rq.operation == OP_WRITE) begin
			if (rq.palette_address < PALETTE_WORDS) begin
				palette_shadow[rq.palette_address] = rq.palette_value;
				palette_written[rq.palette_address] = 1'b1;
			end
		end else begin
			skinned_queue.push_back(skin_vertex(rq));
		end
	endfunction

	// Check whether every palette word a vertex would read has been written
	function automatic bit vertex_safe(req_t rq);
		int slot;
		for (int k = 0; k < MAX_INFLUENCES; k++) begin
			slot = int'(rq.bone_indices[6*k +: 6]);
			if (k > 0 && rq.bone_weights[16*k +: 16] == 0) break;
			if (slot >= BONE_SLOTS) continue;
			for (int e = 0; e < WORDS_PER_BONE; e++)
				if (!palette_written[slot*WORDS_PER_BONE + e]) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic req_t write_req(int addr, logic [31:0] val);
		req_t rq;
		rq = '0;
		rq.operation = OP_WRITE;
		rq.palette_address = 10'(addr);
		rq.palette_value = val;
		return rq;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'(signed'($urandom_range(0, 262144)) - 131072);
			default: return $urandom();
		endcase
	endfunction

	function automatic req_t rand_vertex();
		req_t rq;
		rq = '0;
		rq.operation = OP_SKIN;
		rq.palette_address = 10'($urandom());
		rq.palette_value = $urandom();
		rq.pos_x = rand_word(); rq.pos_y = rand_word(); rq.pos_z = rand_word();
		rq.norm_x = rand_word(); rq.norm_y = rand_word(); rq.norm_z = rand_word();
		for (int k = 0; k < 4; k++) begin
			rq.bone_indices[6*k +: 6] = 6'($urandom());
			case ($urandom_range(0, 5))
				0: rq.bone_weights[16*k +: 16] = 16'h0000;
				1: rq.bone_weights[16*k +: 16] = 16'h8000;
				2: rq.bone_weights[16*k +: 16] = 16'hFFFF;
				default: rq.bone_weights[16*k +: 16] = 16'($urandom());
			endcase
		end
		rq.last_vertex = 1'($urandom());
		return rq;
	endfunction

	// Offer one request and hold it until accepted
	task automatic send_request(req_t rq);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		repeat (gap) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= rq;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		absorb_request(rq);
	endtask

	// Receiver stall pattern, with one long hold-off on request
	initial begin
		int stall_len;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				res_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			stall_len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
				: $urandom_range(0, 2);
			if ($urandom_range(0, 4) == 0) stall_len = 0;
			if (stall_len > 0) begin
				res_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
		end
	end

	// Compare accepted results with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (skinned_queue.size() == 0) begin
				$error("unexpected result %p", res_data);
				fail_count++;
			end else begin
				res_t exp_r;
				exp_r = skinned_queue.pop_front();
				if (res_data.out_pos_x !== exp_r.out_pos_x) begin
					$error("out_pos_x exp %h got %h", exp_r.out_pos_x, res_data.out_pos_x);
					fail_count++;
				end
				if (res_data.out_pos_y !== exp_r.out_pos_y) begin
					$error("out_pos_y exp %h got %h", exp_r.out_pos_y, res_data.out_pos_y);
					fail_count++;
				end
				if (res_data.out_pos_z !== exp_r.out_pos_z) begin
					$error("out_pos_z exp %h got %h", exp_r.out_pos_z, res_data.out_pos_z);
					fail_count++;
				end
				if (res_data.out_norm_x !== exp_r.out_norm_x) begin
					$error("out_norm_x exp %h got %h", exp_r.out_norm_x, res_data.out_norm_x);
					fail_count++;
				end
				if (res_data.out_norm_y !== exp_r.out_norm_y) begin
					$error("out_norm_y exp %h got %h", exp_r.out_norm_y, res_data.out_norm_y);
					fail_count++;
				end
				if (res_data.out_norm_z !== exp_r.out_norm_z) begin
					$error("out_norm_z exp %h got %h", exp_r.out_norm_z, res_data.out_norm_z);
					fail_count++;
				end
				if (res_data.out_last !== exp_r.out_last) begin
					$error("out_last exp %b got %b", exp_r.out_last, res_data.out_last);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: count cycles with no handshake on either side
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Directed table: identity and extreme bones, then vertices over them
	req_t directed_rows [DIRECTED_ROWS];
	res_t directed_expect [DIRECTED_ROWS];
	bit directed_has_expect [DIRECTED_ROWS];

	initial begin
		req_t rq;
		int n_vertices;
		int addr;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bone 0 identity, bone 63 all maximum, bone 1 all minimum
		for (int e = 0; e < WORDS_PER_BONE; e++) begin
			send_request(write_req(e, (e == 0 || e == 4 || e == 8) ? 32'h0001_0000 : 32'h0));
			send_request(write_req(63*WORDS_PER_BONE + e, 32'h7FFF_FFFF));
			send_request(write_req(WORDS_PER_BONE + e, 32'h8000_0000));
		end
		// Write beyond the palette is dropped
		send_request(write_req(1023, 32'hDEAD_BEEF));
		send_request(write_req(PALETTE_WORDS, 32'h1234_5678));

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			directed_rows[i] = '0;
			directed_rows[i].operation = OP_SKIN;
			directed_has_expect[i] = 1'b0;
		end
		// Identity bone, weight one: position and normal pass through
		directed_rows[0].pos_x = 32'h0003_0000; directed_rows[0].pos_y = 32'hFFFF_0000;
		directed_rows[0].pos_z = 32'h7FFF_FFFF; directed_rows[0].norm_x = 32'h8000_0000;
		directed_rows[0].norm_y = 32'h0000_0001; directed_rows[0].norm_z = 32'h0;
		directed_rows[0].bone_weights = 64'h0000_0000_0000_8000;
		directed_rows[0].last_vertex = 1'b1;
		directed_expect[0] = '{32'h0003_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h0000_0001, 32'h0, 1'b1};
		directed_has_expect[0] = 1'b1;
		// Influence zero with zero weight still counts: all-zero matrix
		directed_rows[1].pos_x = 32'h0005_0000;
		directed_rows[1].bone_weights = 64'h0;
		directed_expect[1] = '0;
		directed_has_expect[1] = 1'b1;
		// Maximum bone saturates positive
		directed_rows[2].bone_indices = 24'd63;
		directed_rows[2].pos_x = 32'h7FFF_FFFF; directed_rows[2].pos_y = 32'h7FFF_FFFF;
		directed_rows[2].pos_z = 32'h7FFF_FFFF; directed_rows[2].norm_x = 32'h7FFF_FFFF;
		directed_rows[2].norm_y = 32'h7FFF_FFFF; directed_rows[2].norm_z = 32'h7FFF_FFFF;
		directed_rows[2].bone_weights = 64'hFFFF_FFFF_FFFF_FFFF;
		directed_rows[2].bone_indices = {6'd63, 6'd63, 6'd63, 6'd63};
		directed_expect[2] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0};
		directed_has_expect[2] = 1'b1;
		// Minimum bone with minimum vectors, remaining rows through the predictor
		directed_rows[3].bone_indices = {6'd63, 6'd1, 6'd0, 6'd1};
		directed_rows[3].bone_weights = 64'h8000_0001_FFFF_8000;
		directed_rows[3].pos_x = 32'h8000_0000; directed_rows[3].norm_z = 32'h8000_0000;
		// Zero weight at influence one gates influences two and three
		directed_rows[4].bone_indices = {6'd63, 6'd63, 6'd1, 6'd0};
		directed_rows[4].bone_weights = 64'hFFFF_FFFF_0000_8000;
		directed_rows[4].pos_x = 32'h0001_0000; directed_rows[4].norm_y = 32'hFFFF_FFFF;
		// Zero weight at influence two
		directed_rows[5].bone_indices = {6'd63, 6'd63, 6'd0, 6'd0};
		directed_rows[5].bone_weights = 64'hFFFF_0000_4000_4000;
		directed_rows[5].pos_y = 32'h0002_8000;
		// All four influences, mixed bones
		directed_rows[6].bone_indices = {6'd0, 6'd1, 6'd63, 6'd0};
		directed_rows[6].bone_weights = 64'h2000_0001_0001_2000;
		directed_rows[6].pos_z = 32'hFFFF_FFFF; directed_rows[6].norm_x = 32'h7FFF_FFFF;
		for (int i = 7; i < DIRECTED_ROWS; i++) begin
			directed_rows[i] = rand_vertex();
			directed_rows[i].bone_indices = {6'(63*(i&1)), 6'd1, 6'd0, 6'(63*(i&1))};
		end

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			rq = directed_rows[i];
			send_request(rq);
			if (directed_has_expect[i] &&
			    skinned_queue[skinned_queue.size()-1] !== directed_expect[i]) begin
				$error("table row %0d: predictor gives %p, table %p", i,
					skinned_queue[skinned_queue.size()-1], directed_expect[i]);
				fail_count++;
			end
		end

		// Random part: about one request in three writes a palette word, the rest skin over written slots
		n_vertices = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3) hold_off = 1'b1;
			if ($urandom_range(0, 2) == 0) begin
				addr = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023)
					: $urandom_range(0, PALETTE_WORDS - 1);
				send_request(write_req(addr, rand_word()));
			end else begin
				rq = rand_vertex();
				if (!vertex_safe(rq)) begin
					// keep all slots in written territory
					for (int k = 0; k < 4; k++)
						if (!palette_written[int'(rq.bone_indices[6*k +: 6])*WORDS_PER_BONE]
						    || !vertex_safe(rq))
							rq.bone_indices[6*k +: 6] = 6'($urandom_range(0, 1) ? 63 : 0);
				end
				if (vertex_safe(rq)) begin
					send_request(rq);
					n_vertices++;
				end
			end
		end
		req_valid <= 1'b0;

		while (skinned_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && skinned_queue.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+src
src/lbs_pkg.sv
src/lbs_palette.sv
src/linear_blend_vertex_skinning_top.sv
tb/tb_top.sv
